[rtl/plp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// plp_pkg: shared types and constants of the perspective line projector
// Payload structs, register indexes and divider chain sizing.
// ---------------------------------------------------------------------------
package plp_pkg;

	// divider chain: one quotient bit per cell
	localparam int unsigned NUM_BITS  = 62;
	localparam int unsigned DIV_STEPS = NUM_BITS;
	localparam int unsigned LANES     = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FOCAL       = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_HALF_WIDTH  = 3'd3,
		REG_HALF_HEIGHT = 3'd4
	} plp_reg_t;

	localparam logic [30:0] FOCAL_RST       = 31'd26214400;
	localparam logic [30:0] HALF_WIDTH_RST  = 31'd26214400;
	localparam logic [30:0] HALF_HEIGHT_RST = 31'd19660800;

	typedef struct packed {
		logic        [30:0] focal_distance;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [30:0] half_width;
		logic        [30:0] half_height;
	} plp_cfg_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic        [15:0] line_tag;
	} plp_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x1;
		logic signed [31:0] screen_y1;
		logic signed [31:0] screen_x2;
		logic signed [31:0] screen_y2;
		logic        [15:0] tag_out;
		logic               start_fault;
		logic               end_fault;
	} plp_out_t;

	// one coordinate under division
	typedef struct packed {
		logic [31:0]         rem;   // partial remainder
		logic [NUM_BITS-1:0] acc;   // numerator bits left, quotient bits in
		logic [31:0]         dmag;  // denominator magnitude
		logic                neg;   // quotient sign
		logic                cpos;  // coordinate > 0
		logic                cneg;  // coordinate < 0
		logic                dz;    // denominator is zero
	} plp_lane_t;

	typedef struct packed {
		plp_lane_t [LANES-1:0] lane;
		logic      [15:0]      tag;
	} plp_div_t;

endpackage
`default_nettype wire

[rtl/plp_cfg_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// plp_cfg_regs: configuration register file
// Five registers written by index; writes beyond the list are dropped.
// ---------------------------------------------------------------------------
module plp_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output plp_pkg::plp_cfg_t       cfg
);

	plp_pkg::plp_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_distance <= plp_pkg::FOCAL_RST;
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.half_width     <= plp_pkg::HALF_WIDTH_RST;
			cfg_q.half_height    <= plp_pkg::HALF_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				plp_pkg::REG_FOCAL:       cfg_q.focal_distance <= cfg_data[30:0];
				plp_pkg::REG_CENTER_X:    cfg_q.center_x       <= cfg_data;
				plp_pkg::REG_CENTER_Y:    cfg_q.center_y       <= cfg_data;
				plp_pkg::REG_HALF_WIDTH:  cfg_q.half_width     <= cfg_data[30:0];
				plp_pkg::REG_HALF_HEIGHT: cfg_q.half_height    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/plp_div_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// plp_div_cell: one restoring division step for all four coordinates
// Shifts in one numerator bit, subtracts the divisor where it fits.
// ---------------------------------------------------------------------------
module plp_div_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               up_valid,
	input  wire plp_pkg::plp_div_t  up_data,
	output logic                    valid,
	output plp_pkg::plp_div_t       data
);

	logic              valid_q;
	plp_pkg::plp_div_t data_q;
	plp_pkg::plp_div_t step;

	// one quotient bit per lane
	always_comb begin
		logic [32:0] trial;
		logic [32:0] diff;
		step = up_data;
		for (int l = 0; l < plp_pkg::LANES; l++) begin
			trial = {up_data.lane[l].rem, up_data.lane[l].acc[plp_pkg::NUM_BITS-1]};
			diff  = trial - {1'b0, up_data.lane[l].dmag};
			if (!diff[32]) begin
				step.lane[l].rem = diff[31:0];
				step.lane[l].acc = {up_data.lane[l].acc[plp_pkg::NUM_BITS-2:0], 1'b1};
			end else begin
				step.lane[l].rem = trial[31:0];
				step.lane[l].acc = {up_data.lane[l].acc[plp_pkg::NUM_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= step;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule
`default_nettype wire

[rtl/perspective_line_projector.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// perspective_line_projector: pinhole projection of one 3D line segment
// Multiplies each coordinate by z0, divides by z0+z in a chain of
// division cells, adds the screen offset and saturates.
// ---------------------------------------------------------------------------
//  channel | handshake           | beat
//  in      | in_valid / in_stall | plp_in_t, one segment
//  out     | out_valid/out_stall | plp_out_t, two screen points, tag, faults
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One segment enters per cycle while in_stall is low. The path holds one multiply
// stage, 62 division cells (one quotient bit each) and the offset/saturate output
// register. Reset clears all stage valid bits and loads register defaults.
// A stalled output holds its beat; stages behind it keep filling any empty
// slot, and in_stall rises only once every stage holds a beat.
// ---------------------------------------------------------------------------
module perspective_line_projector (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire plp_pkg::plp_in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output plp_pkg::plp_out_t       out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int unsigned STEPS = plp_pkg::DIV_STEPS;

	plp_pkg::plp_cfg_t cfg;

	logic              valid_c [0:STEPS];
	plp_pkg::plp_div_t data_c  [0:STEPS];
	logic              adv_c   [0:STEPS];
	logic              out_adv;

	logic              valid_s1;
	plp_pkg::plp_div_t data_s1;
	plp_pkg::plp_div_t front;

	logic              out_valid_q;
	plp_pkg::plp_out_t out_q;
	plp_pkg::plp_out_t back;

	logic signed [32:0] off_x;
	logic signed [32:0] off_y;

	plp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// set up one lane: magnitudes, signs and the exact product |c|*z0
	function automatic plp_pkg::plp_lane_t setup(input logic signed [31:0] c,
	                                            input logic signed [31:0] z,
	                                            input logic [30:0] z0);
		plp_pkg::plp_lane_t l;
		logic signed [32:0] d;
		logic [32:0] dn;
		logic [31:0] cm;
		logic [62:0] p;
		d  = $signed({2'b00, z0}) + $signed({z[31], z});
		dn = 33'd0 - d;
		cm = c[31] ? (~c + 32'd1) : c;
		p  = 63'(cm) * 63'(z0);
		l.rem  = '0;
		l.acc  = p[plp_pkg::NUM_BITS-1:0];
		l.dmag = d[32] ? dn[31:0] : d[31:0];
		l.neg  = c[31] ^ d[32];
		l.cpos = !c[31] && (c != 32'sd0);
		l.cneg = c[31];
		l.dz   = (d == 33'sd0);
		return l;
	endfunction

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// final screen coordinate of one lane
	function automatic logic signed [31:0] screen(input plp_pkg::plp_lane_t l,
	                                             input logic signed [32:0] off);
		logic signed [63:0] q;
		logic signed [63:0] o;
		q = $signed({2'b00, l.acc});
		if (l.neg)
			q = -q;
		o = 64'(off);
		if (l.dz) begin
			if (l.cpos)
				return 32'sh7FFFFFFF;
			else if (l.cneg)
				return 32'sh80000000;
			else
				return sat32(o);
		end
		return sat32(q + o);
	endfunction

	// front stage: multiply and form denominators
	always_comb begin
		front.lane[0] = setup(in_data.start_x, in_data.start_z, cfg.focal_distance);
		front.lane[1] = setup(in_data.start_y, in_data.start_z, cfg.focal_distance);
		front.lane[2] = setup(in_data.end_x,   in_data.end_z,   cfg.focal_distance);
		front.lane[3] = setup(in_data.end_y,   in_data.end_z,   cfg.focal_distance);
		front.tag     = in_data.line_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_c[0]) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_c[0]) begin
			data_s1 <= front;
		end
	end

	assign valid_c[0] = valid_s1;
	assign data_c[0]  = data_s1;

	// a stage moves when it is empty or the one after it moves
	assign out_adv = !out_valid_q || !out_stall;
	always_comb begin
		adv_c[STEPS] = !valid_c[STEPS] || out_adv;
		for (int k = STEPS - 1; k >= 0; k--) begin
			adv_c[k] = !valid_c[k] || adv_c[k+1];
		end
	end
	assign in_stall = !adv_c[0];

	// division cell chain
	for (genvar k = 1; k <= STEPS; k++) begin : g_cell
		plp_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (adv_c[k]),
			.up_valid (valid_c[k-1]),
			.up_data  (data_c[k-1]),
			.valid    (valid_c[k]),
			.data     (data_c[k])
		);
	end

	// offsets and saturation into the output register
	assign off_x = $signed({cfg.center_x[31], cfg.center_x}) + $signed({2'b00, cfg.half_width});
	assign off_y = $signed({cfg.center_y[31], cfg.center_y}) + $signed({2'b00, cfg.half_height});

	always_comb begin
		back.screen_x1   = screen(data_c[STEPS].lane[0], off_x);
		back.screen_y1   = screen(data_c[STEPS].lane[1], off_y);
		back.screen_x2   = screen(data_c[STEPS].lane[2], off_x);
		back.screen_y2   = screen(data_c[STEPS].lane[3], off_y);
		back.tag_out     = data_c[STEPS].tag;
		back.start_fault = data_c[STEPS].lane[0].dz;
		back.end_fault   = data_c[STEPS].lane[2].dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_q <= back;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// input backs up only when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	// an accepted beat lands in the front stage
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat lost at front stage");

	// final remainder of lane 0 is below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[STEPS] && !data_c[STEPS].lane[0].dz) |->
		(data_c[STEPS].lane[0].rem < data_c[STEPS].lane[0].dmag))
		else $error("division remainder out of range");
`endif

endmodule
`default_nettype wire

[tb/sv/perspective_line_projector_tb.sv]
// ---------------------------------------------------------------------------
// perspective_line_projector_tb: self-checking bench of the line projector
// Drives segments through the stall handshake, predicts every projected beat
// in the bench, checks it field by field, and sweeps the registers, the
// sender and receiver pacing and a long output hold-off.
// ---------------------------------------------------------------------------
module perspective_line_projector_tb;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam logic [2:0] IDX_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] IDX_LAST_UNUSED  = 3'd7;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		plp_pkg::plp_in_t  seg;
		bit                typed;
		plp_pkg::plp_out_t want;
	} seg_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	plp_pkg::plp_in_t   in_data;
	logic      out_valid;
	logic      out_stall;
	plp_pkg::plp_out_t  out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// register shadow
	longint cur_focal, cur_cx, cur_cy, cur_hw, cur_hh;
	plp_pkg::plp_out_t screen_q[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	seg_row_t rows[$];

	perspective_line_projector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// one screen coordinate: c*z0/(z0+z) plus offset, saturated
	function automatic logic [31:0] screen_coord(longint c, longint den, longint off);
		longint unsigned cm, dm, q;
		longint r;
		if (den == 0) begin
			r = c > 0 ? S32_MAX : (c < 0 ? S32_MIN : off);
		end else begin
			cm = c < 0 ? longint'(-c) : longint'(c);
			dm = den < 0 ? longint'(-den) : longint'(den);
			q = (cm * longint'(cur_focal)) / dm;
			r = ((c < 0) != (den < 0)) ? -longint'(q) : longint'(q);
			r = r + off;
		end
		if (r > S32_MAX) r = S32_MAX;
		if (r < S32_MIN) r = S32_MIN;
		return r[31:0];
	endfunction

	function automatic plp_pkg::plp_out_t project_segment(plp_pkg::plp_in_t s);
		plp_pkg::plp_out_t o;
		longint d1, d2, offx, offy;
		d1 = cur_focal + longint'(s.start_z);
		d2 = cur_focal + longint'(s.end_z);
		offx = cur_cx + cur_hw;
		offy = cur_cy + cur_hh;
		o.screen_x1 = screen_coord(longint'(s.start_x), d1, offx);
		o.screen_y1 = screen_coord(longint'(s.start_y), d1, offy);
		o.screen_x2 = screen_coord(longint'(s.end_x), d2, offx);
		o.screen_y2 = screen_coord(longint'(s.end_y), d2, offy);
		o.tag_out = s.line_tag;
		o.start_fault = (d1 == 0);
		o.end_fault = (d2 == 0);
		return o;
	endfunction

	function automatic plp_pkg::plp_in_t mk_seg(int x1, int y1, int z1, int x2, int y2,
			int z2, logic [15:0] tag);
		plp_pkg::plp_in_t s;
		s.start_x = x1; s.start_y = y1; s.start_z = z1;
		s.end_x = x2; s.end_y = y2; s.end_z = z2;
		s.line_tag = tag;
		return s;
	endfunction

	function automatic plp_pkg::plp_out_t mk_out(int x1, int y1, int x2, int y2,
			logic [15:0] tag, logic f1, logic f2);
		plp_pkg::plp_out_t o;
		o.screen_x1 = x1; o.screen_y1 = y1; o.screen_x2 = x2; o.screen_y2 = y2;
		o.tag_out = tag; o.start_fault = f1; o.end_fault = f2;
		return o;
	endfunction

	// append one directed row
	task automatic add_row(plp_pkg::plp_in_t seg, bit typed, plp_pkg::plp_out_t want);
		seg_row_t r;
		r.seg = seg;
		r.typed = typed;
		r.want = want;
		rows.insert(rows.size(), r);
	endtask

	// register write; shadow follows only for mapped indexes
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			plp_pkg::REG_FOCAL:       cur_focal = longint'(val[30:0]);
			plp_pkg::REG_CENTER_X:    cur_cx = longint'(signed'(val));
			plp_pkg::REG_CENTER_Y:    cur_cy = longint'(signed'(val));
			plp_pkg::REG_HALF_WIDTH:  cur_hw = longint'(val[30:0]);
			plp_pkg::REG_HALF_HEIGHT: cur_hh = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	// one segment beat; want is used when typed, else the predictor
	task automatic send_seg(plp_pkg::plp_in_t s, bit typed, plp_pkg::plp_out_t want);
		int gap;
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall);
		screen_q.insert(screen_q.size(), typed ? want : project_segment(s));
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(3, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (screen_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sd0;
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(32'h01ffffff)) - 32'sh00ffffff;
		endcase
	endfunction

	function automatic logic [31:0] rnd_depth();
		case ($urandom_range(7))
			0, 1: return -cur_focal[31:0];   // zero denominator
			2: return $urandom;
			3: return -cur_focal[31:0] + $signed($urandom_range(4)) - 2;
			default: return $signed($urandom_range(32'h01ffffff)) - 32'sh00ffffff;
		endcase
	endfunction

	task automatic send_random(int n);
		plp_pkg::plp_in_t s;
		repeat (n) begin
			s = mk_seg(rnd_coord(), rnd_coord(), rnd_depth(),
				rnd_coord(), rnd_coord(), rnd_depth(), 16'($urandom));
			send_seg(s, 1'b0, '0);
		end
	endtask

	task automatic write_all(logic [31:0] f, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] hw, logic [31:0] hh);
		write_reg(plp_pkg::REG_FOCAL, f);
		write_reg(plp_pkg::REG_CENTER_X, cx);
		write_reg(plp_pkg::REG_CENTER_Y, cy);
		write_reg(plp_pkg::REG_HALF_WIDTH, hw);
		write_reg(plp_pkg::REG_HALF_HEIGHT, hh);
	endtask

	// receiver: random stall, long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		plp_pkg::plp_out_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (screen_q.size() == 0) begin
				$error("unexpected result beat %p", out_data);
				errors++;
			end else begin
				w = screen_q.pop_front();
				if (out_data.screen_x1 !== w.screen_x1) begin
					$error("screen_x1 exp %0d got %0d", w.screen_x1, out_data.screen_x1);
					errors++;
				end
				if (out_data.screen_y1 !== w.screen_y1) begin
					$error("screen_y1 exp %0d got %0d", w.screen_y1, out_data.screen_y1);
					errors++;
				end
				if (out_data.screen_x2 !== w.screen_x2) begin
					$error("screen_x2 exp %0d got %0d", w.screen_x2, out_data.screen_x2);
					errors++;
				end
				if (out_data.screen_y2 !== w.screen_y2) begin
					$error("screen_y2 exp %0d got %0d", w.screen_y2, out_data.screen_y2);
					errors++;
				end
				if (out_data.tag_out !== w.tag_out) begin
					$error("tag_out exp %0h got %0h", w.tag_out, out_data.tag_out);
					errors++;
				end
				if (out_data.start_fault !== w.start_fault) begin
					$error("start_fault exp %0b got %0b", w.start_fault, out_data.start_fault);
					errors++;
				end
				if (out_data.end_fault !== w.end_fault) begin
					$error("end_fault exp %0b got %0b", w.end_fault, out_data.end_fault);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_focal = longint'(plp_pkg::FOCAL_RST);
		cur_cx = 0;
		cur_cy = 0;
		cur_hw = longint'(plp_pkg::HALF_WIDTH_RST);
		cur_hh = longint'(plp_pkg::HALF_HEIGHT_RST);

		// directed table, reset register values
		add_row(mk_seg(0, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
			mk_out(26214400, 19660800, 26214400, 19660800, 16'h0000, 1'b0, 1'b0));
		// zero denominator on both ends: positive, negative and zero numerators
		add_row(mk_seg(5, -5, -26214400, 0, 0, -26214400, 16'hffff), 1'b1,
			mk_out(32'h7fffffff, 32'h80000000, 26214400, 19660800, 16'hffff, 1'b1, 1'b1));
		// second end: 1*z0/(z0+3) truncates to 0, 2*z0/(z0+3) to 1
		add_row(mk_seg(32'h80000000, 7, -26214400, 1, 2, 3, 16'h1234), 1'b1,
			mk_out(32'h80000000, 32'h7fffffff, 26214400, 19660801, 16'h1234, 1'b1, 1'b0));
		add_row(mk_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8001), 1'b0, '0);
		// denominator of one: overflow both ways
		add_row(mk_seg(32'h7fffffff, 32'h80000000, -26214399,
			32'h00010000, 32'hffff0000, -26214399, 16'h00ff), 1'b1,
			mk_out(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h00ff,
			1'b0, 1'b0));
		// point behind the viewer
		add_row(mk_seg(32'h00640000, 32'hff9c0000, 32'h80000000,
			32'h00010000, 32'h00020000, -26214401, 16'h5a5a), 1'b0, '0);
		add_row(mk_seg(32'h00010000, 32'h00010000, 32'h00010000,
			32'hffff0000, 32'hffff0000, 32'hffff0000, 16'ha5a5), 1'b0, '0);
		add_row(mk_seg(-1, 1, 32'h7fffffff, 1, -1, 32'h80000001, 16'h0001), 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_seg(rows[i].seg, rows[i].typed, rows[i].want);
		drain();

		// extremes: widest focal, center at the rails
		write_all(32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00000000);
		send_seg(mk_seg(32'h7fffffff, 32'h80000000, 0, 0, 0, 32'h80000001, 16'h0f0f),
			1'b0, '0);
		send_random(110);
		drain();

		// zero focal: projection collapses, depth zero faults
		idle_pct = 50;
		write_all(32'h00000000, $urandom, $urandom, $urandom, $urandom);
		write_reg(3'($urandom_range(IDX_LAST_UNUSED, IDX_FIRST_UNUSED)), $urandom);
		send_seg(mk_seg(3, -3, 0, 0, 4, 1, 16'h7777), 1'b0, '0);
		send_random(110);
		drain();

		idle_pct = 0;
		stall_pct = 50;
		write_all($urandom, $urandom, $urandom, $urandom, $urandom);
		write_reg(IDX_FIRST_UNUSED, 32'hffffffff);
		write_reg(IDX_LAST_UNUSED, 32'h00000000);
		send_random(110);
		drain();

		idle_pct = 14;
		stall_pct = 14;
		write_all($urandom_range(32'h00100000), $signed($urandom_range(32'h00ffffff)) - 32'sh7fffff,
			$signed($urandom_range(32'h00ffffff)) - 32'sh7fffff,
			$urandom_range(32'h01000000), $urandom_range(32'h01000000));
		send_random(110);
		drain();

		// long output hold-off with the sender pushing, then a full drain
		idle_pct = 0;
		stall_pct = 0;
		write_all(32'(plp_pkg::FOCAL_RST), 0, 0, 32'(plp_pkg::HALF_WIDTH_RST),
			32'(plp_pkg::HALF_HEIGHT_RST));
		hold_req = 300;
		send_random(100);
		drain();

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
